// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent property checked on the rising clock edge, disabled in reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/bsd_pkg.sv
// Package: constants and types of the biphase sync deframer.
`default_nettype none
package bsd_pkg;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_INVERTED = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_NORMAL   = 2'd2;

   localparam logic [7:0]  FRAME_LENGTH_RESET  = 8'd33;
   localparam logic [31:0] SYNC_INVERTED_RESET = 32'h6566_A5AA;
   localparam logic [31:0] SYNC_NORMAL_RESET   = 32'h9A99_5A55;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic       last_of_frame;
      logic       polarity_inverted;
   } rsp_type;
endpackage
`default_nettype wire

// File: rtl/bsd_req_if.sv
// Interface: raw byte input channel.
`default_nettype none
interface bsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] raw_byte;
   modport source (output valid, output raw_byte, input ready);
   modport sink (input valid, input raw_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/bsd_rsp_if.sv
// Interface: decoded byte result channel.
`default_nettype none
interface bsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic       last_of_frame;
   logic       polarity_inverted;
   modport source (output valid, output data_byte, output byte_index,
                   output last_of_frame, output polarity_inverted, input ready);
   modport sink (input valid, input data_byte, input byte_index,
                 input last_of_frame, input polarity_inverted, output ready);
endinterface
`default_nettype wire

// File: rtl/bsd_csr_if.sv
// Interface: register write channel.
`default_nettype none
interface bsd_csr_if;
   import bsd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/biphase_sync_deframer.sv
// Top level: biphase sync deframer with sync word search and byte output.
// A completed data byte is registered into out_ff, or into skid_ff while rsp stalls.
// Throughput: one raw byte per cycle while skid is empty; eight bit steps, combinational.
// A two-entry result buffer (output register plus skid) lets req run on while rsp stalls.
// Reset (synchronous, active high): searching, history and counters cleared,
// registers back to frame length 33 and the default sync words.
`default_nettype none
`include "assert_macros.svh"
module biphase_sync_deframer (
   input wire logic clock,
   input wire logic reset,
   bsd_req_if.sink   req_chan,
   bsd_rsp_if.source rsp_chan,
   bsd_csr_if.sink   csr_chan
);
   import bsd_pkg::*;

   // configuration registers
   logic [7:0]  frame_length_ff;
   logic [31:0] sync_inverted_ff;
   logic [31:0] sync_normal_ff;

   // deframer state
   logic [31:0] bit_history_ff, bit_history_in;
   logic [3:0]  half_bit_phase_ff, half_bit_phase_in;
   logic [7:0]  assembly_byte_ff, assembly_byte_in;
   logic        searching_ff, searching_in;
   logic [7:0]  frame_position_ff, frame_position_in;
   logic        invert_flag_ff, invert_flag_in;

   // result buffer: output register and skid entry
   rsp_type res_in;
   logic    res_valid_in;
   rsp_type out_ff, skid_ff;
   logic    out_valid_ff, skid_valid_ff;

   logic req_beat, rsp_beat, push;

   // req may run while the output waits, as long as the skid entry is free
   assign req_chan.ready = !skid_valid_ff;
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign rsp_beat       = out_valid_ff && rsp_chan.ready;
   assign push           = req_beat && res_valid_in;

   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.data_byte         = out_ff.data_byte;
   assign rsp_chan.byte_index        = out_ff.byte_index;
   assign rsp_chan.last_of_frame     = out_ff.last_of_frame;
   assign rsp_chan.polarity_inverted = out_ff.polarity_inverted;

   // Eight chained bit steps, MSB first. Each step shifts the history,
   // collects the first half of each Manchester pair and either searches
   // for a sync word or advances the half-bit phase. A byte needs 16 line
   // bits, so one raw byte yields at most one result.
   always_comb begin
      logic [7:0] raw;
      logic       bit_d;
      logic       hit_inv;
      logic       last;
      raw               = req_chan.raw_byte;
      bit_d             = 1'b0;
      hit_inv           = 1'b0;
      last              = 1'b0;
      bit_history_in    = bit_history_ff;
      half_bit_phase_in = half_bit_phase_ff;
      assembly_byte_in  = assembly_byte_ff;
      searching_in      = searching_ff;
      frame_position_in = frame_position_ff;
      invert_flag_in    = invert_flag_ff;
      res_valid_in      = 1'b0;
      res_in            = '0;
      for (int i = 0; i < 8; i++) begin
         bit_d          = raw[7];
         raw            = {raw[6:0], 1'b0};
         bit_history_in = {bit_history_in[30:0], bit_d};
         // assembly keeps shifting during search; cleared on a sync match
         if (!half_bit_phase_in[0]) begin
            assembly_byte_in = {assembly_byte_in[6:0], bit_d};
         end
         if (searching_in) begin
            hit_inv = (bit_history_in == sync_inverted_ff);
            // equal sync words: inverted wins
            if (hit_inv || (bit_history_in == sync_normal_ff)) begin
               searching_in      = 1'b0;
               half_bit_phase_in = '0;
               frame_position_in = '0;
               assembly_byte_in  = '0;
               invert_flag_in    = hit_inv;
            end
         end else begin
            half_bit_phase_in = half_bit_phase_in + 4'd1;
            if (half_bit_phase_in == 4'd0) begin
               res_in.data_byte  = invert_flag_in ? ~assembly_byte_in : assembly_byte_in;
               res_in.byte_index = frame_position_in;
               frame_position_in = frame_position_in + 8'd1;
               // a zero frame length acts as one; position wrap also ends the frame
               last = (frame_position_in == 8'd0) || (frame_position_in >= frame_length_ff);
               if (last) begin
                  searching_in = 1'b1;
               end
               res_in.last_of_frame     = last;
               res_in.polarity_inverted = invert_flag_in;
               res_valid_in             = 1'b1;
            end
         end
      end
   end

   // deframer state advances once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_history_ff    <= '0;
         half_bit_phase_ff <= '0;
         assembly_byte_ff  <= '0;
         searching_ff      <= 1'b1;
         frame_position_ff <= '0;
         invert_flag_ff    <= 1'b0;
      end else if (req_beat) begin
         bit_history_ff    <= bit_history_in;
         half_bit_phase_ff <= half_bit_phase_in;
         assembly_byte_ff  <= assembly_byte_in;
         searching_ff      <= searching_in;
         frame_position_ff <= frame_position_in;
         invert_flag_ff    <= invert_flag_in;
      end
   end

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff  <= FRAME_LENGTH_RESET;
         sync_inverted_ff <= SYNC_INVERTED_RESET;
         sync_normal_ff   <= SYNC_NORMAL_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_FRAME_LENGTH:  frame_length_ff  <= csr_chan.data[7:0];
            CSR_SYNC_INVERTED: sync_inverted_ff <= csr_chan.data;
            CSR_SYNC_NORMAL:   sync_normal_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // result buffer control: skid drains first, new results fill the free slot
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_beat) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !rsp_beat) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_beat) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_beat) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !rsp_beat) begin
            skid_ff <= res_in;
         end else begin
            out_ff <= res_in;
         end
      end
   end

   // skid entry only ever sits behind a full output register
   `ASSERT_PROP(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff)
   // half-bit phase is zero whenever the search is running
   `ASSERT_PROP(a_phase_zero_searching, clock, reset, !searching_ff || (half_bit_phase_ff == 4'd0))
   // a result arriving at a stalled output lands in the skid entry
   `ASSERT_NEXT(a_stall_to_skid, clock, reset, push && out_valid_ff && !rsp_beat, skid_valid_ff)

endmodule
`default_nettype wire
